>>> src/vsl_pkg.sv
`default_nettype none

package vsl_pkg;

    // Line storage depth and derived widths
    localparam int MAX_ROW_WIDTH = 2048;
    localparam int COL_W  = $clog2(MAX_ROW_WIDTH);
    localparam int WID_W  = COL_W + 1;
    localparam int PIX_W  = 8;
    localparam int STEP_W = 8;
    localparam int RW_W   = 12;
    localparam int CMP_W  = (RW_W > WID_W) ? RW_W : WID_W;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    typedef enum logic [0:0] {
        REG_MAX_STEP  = 1'b0,
        REG_ROW_WIDTH = 1'b1
    } reg_idx_t;

    localparam logic [STEP_W-1:0] MAX_STEP_RST  = 8'd255;
    localparam logic [RW_W-1:0]   ROW_WIDTH_RST = 12'd2048;

    // Settings seen by the datapath
    typedef struct packed {
        logic [STEP_W-1:0] max_step;
        logic [WID_W-1:0]  width;
    } vsl_cfg_t;

    // Column tracking status of the datapath
    typedef struct packed {
        logic             acc;
        logic             acc_last;
        logic [COL_W-1:0] acc_col;
        logic [COL_W-1:0] col_count;
    } vsl_stat_t;

endpackage

`default_nettype wire

>>> src/vertical_slope_limiter.sv
// An accepted item is held in the stage register and then in the output register,
// from which it is offered on the m_ channel.
// Throughput: 1 item per cycle while the output is not stalled, set by the line
// store's one read and one write per cycle; a stall backs up via one stage register.
// Reset (aresetn low, synchronous): pipeline emptied, column cleared, first-row
// flag set, max_step to 255, row_width to 2048; the line store is not cleared.
`default_nettype none

module vertical_slope_limiter (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [vsl_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [vsl_pkg::DATA_W-1:0]   pwdata,
    output logic      [vsl_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [vsl_pkg::PIX_W-1:0]    s_pixel_in,
    input  wire logic                         s_frame_start,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [vsl_pkg::PIX_W-1:0]    m_pixel_out,
    output logic                              m_row_end
);

    vsl_pkg::vsl_cfg_t  cfg;
    vsl_pkg::vsl_stat_t stat;

    vsl_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vsl_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_in    (s_pixel_in),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_out   (m_pixel_out),
        .m_row_end     (m_row_end),
        .stat          (stat)
    );

    // Reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // An empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // Last pixel of a row wraps the column back to zero
    a_col_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.acc && stat.acc_last) |=> (stat.col_count == '0))
        else $error("column did not wrap at row end");

    // Any other pixel moves the column on by one
    a_col_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.acc && !stat.acc_last) |=>
            (stat.col_count == vsl_pkg::COL_W'($past(stat.acc_col) + 1'b1)))
        else $error("column did not advance by one");

endmodule

`default_nettype wire

>>> src/vsl_regs.sv
`default_nettype none

module vsl_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vsl_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [vsl_pkg::DATA_W-1:0]    pwdata,
    output logic      [vsl_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    output vsl_pkg::vsl_cfg_t                  cfg
);

    logic [vsl_pkg::STEP_W-1:0] max_step_reg;
    logic [vsl_pkg::RW_W-1:0]   row_width_reg;
    logic                       wr_en;
    vsl_pkg::reg_idx_t          idx;
    logic [vsl_pkg::CMP_W-1:0]  rw_ext;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = vsl_pkg::reg_idx_t'(paddr[2]);

    // Write registers on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_step_reg  <= vsl_pkg::MAX_STEP_RST;
            row_width_reg <= vsl_pkg::ROW_WIDTH_RST;
        end else if (wr_en) begin
            unique case (idx)
                vsl_pkg::REG_MAX_STEP:  max_step_reg  <= pwdata[vsl_pkg::STEP_W-1:0];
                vsl_pkg::REG_ROW_WIDTH: row_width_reg <= pwdata[vsl_pkg::RW_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (idx)
            vsl_pkg::REG_MAX_STEP:  prdata = vsl_pkg::DATA_W'(max_step_reg);
            vsl_pkg::REG_ROW_WIDTH: prdata = vsl_pkg::DATA_W'(row_width_reg);
            default:                prdata = '0;
        endcase
    end

    // Clamp the row width to the range of the line store
    assign rw_ext = vsl_pkg::CMP_W'(row_width_reg);

    always_comb begin
        cfg.max_step = max_step_reg;
        priority if (rw_ext == '0) begin
            cfg.width = vsl_pkg::WID_W'(1);
        end else if (rw_ext > vsl_pkg::CMP_W'(vsl_pkg::MAX_ROW_WIDTH)) begin
            cfg.width = vsl_pkg::WID_W'(vsl_pkg::MAX_ROW_WIDTH);
        end else begin
            cfg.width = vsl_pkg::WID_W'(rw_ext);
        end
    end

endmodule

`default_nettype wire

>>> src/vsl_line_mem.sv
`default_nettype none

module vsl_line_mem (
    input  wire logic                         aclk,
    input  wire logic                         rd_en,
    input  wire logic [vsl_pkg::COL_W-1:0]    rd_addr,
    output logic      [vsl_pkg::PIX_W-1:0]    rd_data,
    input  wire logic                         wr_en,
    input  wire logic [vsl_pkg::COL_W-1:0]    wr_addr,
    input  wire logic [vsl_pkg::PIX_W-1:0]    wr_data
);

    logic [vsl_pkg::PIX_W-1:0] mem [vsl_pkg::MAX_ROW_WIDTH];
    logic [vsl_pkg::PIX_W-1:0] rd_data_reg;

    // One write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> src/vsl_core.sv
`default_nettype none

module vsl_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire vsl_pkg::vsl_cfg_t            cfg,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [vsl_pkg::PIX_W-1:0]    s_pixel_in,
    input  wire logic                         s_frame_start,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [vsl_pkg::PIX_W-1:0]    m_pixel_out,
    output logic                              m_row_end,
    output vsl_pkg::vsl_stat_t                stat
);

    localparam int SUM_W = vsl_pkg::PIX_W + 1;

    // Column tracking
    logic [vsl_pkg::COL_W-1:0] col_count_reg, col_count_next;
    logic                      first_row_reg, first_row_next;
    logic [vsl_pkg::COL_W-1:0] cur_col, col;
    logic                      cur_first, last, acc;

    // Stage register
    logic                      stg_valid_reg;
    logic [vsl_pkg::COL_W-1:0] stg_col_reg;
    logic [vsl_pkg::PIX_W-1:0] stg_pix_reg;
    logic                      stg_first_reg, stg_last_reg;
    logic                      byp_reg, byp_next;
    logic [vsl_pkg::PIX_W-1:0] byp_data_reg;
    logic                      stg_adv;

    // Output register
    logic                      out_valid_reg;
    logic [vsl_pkg::PIX_W-1:0] out_pix_reg;
    logic                      out_end_reg;
    logic                      out_free;

    // Limiter datapath
    logic [vsl_pkg::PIX_W-1:0] mem_rd_data, above, result;
    logic [SUM_W-1:0]          sum;

    assign out_free = !out_valid_reg || m_ready;
    assign stg_adv  = stg_valid_reg && out_free;
    assign s_ready  = !stg_valid_reg || out_free;
    assign acc      = s_valid && s_ready;

    // Locate the column of the offered item
    always_comb begin
        cur_col   = s_frame_start ? '0 : col_count_reg;
        cur_first = s_frame_start || first_row_reg;
        if ({1'b0, cur_col} >= cfg.width) begin
            col = vsl_pkg::COL_W'(cfg.width - 1'b1);
        end else begin
            col = cur_col;
        end
        last           = ({1'b0, col} == (cfg.width - 1'b1));
        col_count_next = last ? '0 : col + 1'b1;
        first_row_next = last ? 1'b0 : cur_first;
        byp_next       = stg_adv && (stg_col_reg == col);
    end

    // Advance column state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            first_row_reg <= 1'b1;
        end else if (acc) begin
            col_count_reg <= col_count_next;
            first_row_reg <= first_row_next;
        end
    end

    vsl_line_mem u_line_mem (
        .aclk    (aclk),
        .rd_en   (acc),
        .rd_addr (col),
        .rd_data (mem_rd_data),
        .wr_en   (stg_adv),
        .wr_addr (stg_col_reg),
        .wr_data (result)
    );

    // Take the pixel above from the store, or from the item just written there
    assign above = byp_reg ? byp_data_reg : mem_rd_data;
    assign sum   = SUM_W'(above) + SUM_W'(cfg.max_step);

    always_comb begin
        if (!stg_first_reg && (SUM_W'(stg_pix_reg) > sum)) begin
            result = sum[vsl_pkg::PIX_W-1:0];
        end else begin
            result = stg_pix_reg;
        end
    end

    // Hold the item in the stage until the output register frees up
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else if (s_ready) begin
            stg_valid_reg <= s_valid;
        end
        if (acc) begin
            stg_col_reg   <= col;
            stg_pix_reg   <= s_pixel_in;
            stg_first_reg <= cur_first;
            stg_last_reg  <= last;
            byp_reg       <= byp_next;
            byp_data_reg  <= result;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= stg_valid_reg;
        end
        if (stg_adv) begin
            out_pix_reg <= result;
            out_end_reg <= stg_last_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_pixel_out = out_pix_reg;
    assign m_row_end   = out_end_reg;

    assign stat.acc       = acc;
    assign stat.acc_last  = last;
    assign stat.acc_col   = col;
    assign stat.col_count = col_count_reg;

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int PIPE_LATENCY = 2;
    localparam int QUIET_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 425;

    typedef struct packed {
        logic [vsl_pkg::PIX_W-1:0] pix;
        logic                      row_end;
    } pixel_result_t;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_SET_STEP,
        ROW_SET_WIDTH
    } row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [11:0]               val;
        logic                      fs;
        logic                      typed;
        logic [vsl_pkg::PIX_W-1:0] want_pix;
        logic                      want_end;
    } dir_row_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [vsl_pkg::ADDR_W-1:0]   paddr;
    logic [vsl_pkg::DATA_W-1:0]   pwdata;
    logic [vsl_pkg::DATA_W-1:0]   prdata;
    logic                         pready;
    logic                         s_valid;
    logic                         s_ready;
    logic [vsl_pkg::PIX_W-1:0]    s_pixel_in;
    logic                         s_frame_start;
    logic                         m_valid;
    logic                         m_ready;
    logic [vsl_pkg::PIX_W-1:0]    m_pixel_out;
    logic                         m_row_end;

    vertical_slope_limiter u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_in    (s_pixel_in),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_out   (m_pixel_out),
        .m_row_end     (m_row_end)
    );

    // Directed items: reset state, width of zero, step extremes, frame start,
    // limiting at the boundary, and a width shrunk in the middle of a row
    dir_row_t directed_rows [27] = '{
        '{ROW_ITEM,      12'd0,   1'b0, 1'b1, 8'd0,   1'b0},
        '{ROW_ITEM,      12'd255, 1'b0, 1'b1, 8'd255, 1'b0},
        '{ROW_SET_WIDTH, 12'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_SET_STEP,  12'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,      12'd100, 1'b1, 1'b1, 8'd100, 1'b1},
        '{ROW_ITEM,      12'd255, 1'b0, 1'b1, 8'd100, 1'b1},
        '{ROW_ITEM,      12'd50,  1'b0, 1'b1, 8'd50,  1'b1},
        '{ROW_ITEM,      12'd50,  1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_SET_STEP,  12'd255, 1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,      12'd255, 1'b0, 1'b1, 8'd255, 1'b1},
        '{ROW_ITEM,      12'd0,   1'b0, 1'b1, 8'd0,   1'b1},
        '{ROW_SET_STEP,  12'd3,   1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_SET_WIDTH, 12'd4,   1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,      12'd10,  1'b1, 1'b1, 8'd10,  1'b0},
        '{ROW_ITEM,      12'd20,  1'b0, 1'b1, 8'd20,  1'b0},
        '{ROW_ITEM,      12'd30,  1'b0, 1'b1, 8'd30,  1'b0},
        '{ROW_ITEM,      12'd40,  1'b0, 1'b1, 8'd40,  1'b1},
        '{ROW_ITEM,      12'd14,  1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,      12'd23,  1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,      12'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,      12'd255, 1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,      12'd7,   1'b1, 1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,      12'd9,   1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_SET_WIDTH, 12'd2,   1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,      12'd200, 1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,      12'd255, 1'b0, 1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,      12'd255, 1'b0, 1'b0, 8'd0,   1'b0}
    };

    // Predictor state
    logic [vsl_pkg::PIX_W-1:0]  line_buf     [vsl_pkg::MAX_ROW_WIDTH];
    bit                         line_written [vsl_pkg::MAX_ROW_WIDTH];
    int unsigned                col_next;
    bit                         first_row;
    logic [vsl_pkg::STEP_W-1:0] cfg_step;
    logic [vsl_pkg::RW_W-1:0]   cfg_width;

    pixel_result_t pending_pixels [$];
    pixel_result_t head;
    int            errors;
    int            quiet_cycles;
    int unsigned   random_items;
    bit            burst;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int unsigned eff_width();
        if (cfg_width == 0)
            return 1;
        if (cfg_width > vsl_pkg::MAX_ROW_WIDTH)
            return vsl_pkg::MAX_ROW_WIDTH;
        return cfg_width;
    endfunction

    function automatic int unsigned current_col(input logic fs);
        int unsigned w;
        int unsigned c;
        w = eff_width();
        c = fs ? 0 : col_next;
        return (c >= w) ? w - 1 : c;
    endfunction

    // Limit one pixel against the stored row above and advance the column
    function automatic pixel_result_t limit_pixel(input logic [vsl_pkg::PIX_W-1:0] pix,
                                                  input logic fs);
        pixel_result_t r;
        int unsigned   col;
        logic [8:0]    ceiling;
        if (fs) begin
            col_next  = 0;
            first_row = 1'b1;
        end
        col   = current_col(1'b0);
        r.pix = pix;
        if (!first_row) begin
            ceiling = 9'(line_buf[col]) + 9'(cfg_step);
            if (9'(pix) > ceiling)
                r.pix = ceiling[7:0];
        end
        line_buf[col]     = r.pix;
        line_written[col] = 1'b1;
        r.row_end = (col == eff_width() - 1);
        if (r.row_end) begin
            col_next  = 0;
            first_row = 1'b0;
        end else begin
            col_next = col + 1;
        end
        return r;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Favour values near the limit of the pixel above
    function automatic logic [vsl_pkg::PIX_W-1:0] pick_pixel(input logic fs);
        int unsigned r;
        int unsigned col;
        int          v;
        r   = $urandom_range(0, 9);
        col = current_col(fs);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'd255;
        if (r < 5 && !fs && !first_row && line_written[col]) begin
            v = int'(line_buf[col]) + int'(cfg_step) + int'($urandom_range(0, 2)) - 1;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            return v[7:0];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Present one item and record its expected result once accepted
    task automatic send_item(input logic [vsl_pkg::PIX_W-1:0] pix, input logic fs_in,
                             input logic typed, input pixel_result_t typed_res);
        int unsigned   gap;
        logic          fs;
        pixel_result_t res;
        gap = idle_len();
        fs  = fs_in;
        // Start a new image rather than read a line entry never written
        if (!fs && !first_row && !line_written[current_col(1'b0)])
            fs = 1'b1;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel_in    <= pix;
        s_frame_start <= fs;
        do @(posedge aclk); while (!s_ready);
        res = limit_pixel(pix, fs);
        pending_pixels = {pending_pixels, (typed ? typed_res : res)};
        @(negedge aclk);
    endtask

    // Hold the input until every expected item has come out
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LATENCY + 2) @(negedge aclk);
    endtask

    task automatic write_reg(input vsl_pkg::reg_idx_t idx,
                             input logic [vsl_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= vsl_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            vsl_pkg::REG_MAX_STEP:  cfg_step  = value[vsl_pkg::STEP_W-1:0];
            vsl_pkg::REG_ROW_WIDTH: cfg_width = value[vsl_pkg::RW_W-1:0];
            default: ;
        endcase
    endtask

    task automatic run_phase(input bit full_width);
        int unsigned   r;
        int unsigned   w;
        int unsigned   frames;
        int unsigned   n;
        logic          fs;
        pixel_result_t none;
        none = '0;
        drain();
        burst = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 5);
        if (full_width || $urandom_range(0, 9) < 7)
            write_reg(vsl_pkg::REG_MAX_STEP, (r == 0) ? 0 : (r == 1) ? 255 :
                      (r < 4) ? $urandom_range(0, 12) : $urandom_range(0, 255));
        r = $urandom_range(0, 9);
        if (full_width)
            write_reg(vsl_pkg::REG_ROW_WIDTH, 4095);
        else if ($urandom_range(0, 9) < 7)
            write_reg(vsl_pkg::REG_ROW_WIDTH, (r == 0) ? 0 : (r == 1) ? 1 :
                      (r == 2) ? $urandom_range(17, 64) : $urandom_range(2, 16));
        w      = eff_width();
        frames = full_width ? 1 : $urandom_range(1, 3);
        for (int f = 0; f < frames && random_items < RANDOM_ITEMS; f++) begin
            n = full_width ? 40 : $urandom_range(1, 4) * w;
            // Cut some images short
            if (!full_width && $urandom_range(0, 4) == 0)
                n = $urandom_range(1, n);
            for (int i = 0; i < n && random_items < RANDOM_ITEMS; i++) begin
                fs = (i == 0 && (full_width || f > 0 || $urandom_range(0, 1) == 0)) ||
                     ($urandom_range(0, 32) == 0);
                send_item(pick_pixel(fs), fs, 1'b0, none);
                random_items++;
            end
        end
    endtask

    // Output stalls
    initial begin
        int unsigned n;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            n = idle_len();
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
    end

    // Compare each output item with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected item: pixel_out %0d row_end %0b", m_pixel_out, m_row_end);
                errors++;
            end else begin
                head = pending_pixels.pop_front();
                if (m_pixel_out !== head.pix) begin
                    $error("pixel_out mismatch: expected %0d, got %0d", head.pix, m_pixel_out);
                    errors++;
                end
                if (m_row_end !== head.row_end) begin
                    $error("row_end mismatch: expected %0b, got %0b", head.row_end, m_row_end);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no traffic
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        pixel_result_t typed_res;
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_valid       = 1'b0;
        s_pixel_in    = '0;
        s_frame_start = 1'b0;
        burst         = 1'b0;
        errors        = 0;
        quiet_cycles  = 0;
        random_items  = 0;
        col_next      = 0;
        first_row     = 1'b1;
        cfg_step      = vsl_pkg::MAX_STEP_RST;
        cfg_width     = vsl_pkg::ROW_WIDTH_RST;
        foreach (line_written[i])
            line_written[i] = 1'b0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part
        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_SET_STEP: begin
                    drain();
                    write_reg(vsl_pkg::REG_MAX_STEP, directed_rows[i].val);
                end
                ROW_SET_WIDTH: begin
                    drain();
                    write_reg(vsl_pkg::REG_ROW_WIDTH, directed_rows[i].val);
                end
                default: begin
                    typed_res.pix     = directed_rows[i].want_pix;
                    typed_res.row_end = directed_rows[i].want_end;
                    send_item(directed_rows[i].val[7:0], directed_rows[i].fs,
                              directed_rows[i].typed, typed_res);
                end
            endcase
        end

        // Random phases, the first of them with the row width saturated
        for (int phase = 0; random_items < RANDOM_ITEMS; phase++)
            run_phase(phase == 0);

        // Wait out the pipeline
        s_valid <= 1'b0;
        burst   = 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LATENCY + 8) @(posedge aclk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
